>>> rtl/core/blpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_pkg
// Shared types and constants of the button long press classifier: poll and
// event payloads, action and interaction codes, volume command values.
// ----------------------------------------------------------------------------
package blpc_pkg;

  // number of buttons polled per item
  localparam int unsigned NumBtn = 4;
  // width of the hold time register and of the timestamp field
  localparam int unsigned HoldW = 48;
  localparam int unsigned StampW = 48;
  // default time modulus width
  localparam int unsigned TimeWDefault = 48;
  // hold time after reset in microseconds
  localparam logic [HoldW-1:0] HoldReset = 48'd2000000;

  // volume command values
  localparam logic signed [7:0] VolMax  = 8'sd100;
  localparam logic signed [7:0] VolMin  = 8'sd0;
  localparam logic signed [7:0] VolUp   = 8'sd10;
  localparam logic signed [7:0] VolDown = -8'sd10;
  localparam logic signed [7:0] VolNone = 8'sd0;

  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_LONG    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    INTER_NONE   = 2'd0,
    INTER_DOWN   = 2'd1,
    INTER_UP     = 2'd2,
    INTER_TOGGLE = 2'd3
  } inter_e;

  // one poll: active-low button levels and a microsecond timestamp
  typedef struct packed {
    logic [3:0]        pin_levels;
    logic [StampW-1:0] now_time;
  } poll_t;

  // one classified event
  typedef struct packed {
    logic [1:0]        button;
    action_e           action;
    inter_e            interaction;
    logic              volume_valid;
    logic signed [7:0] volume_value;
    logic              last;
  } event_t;

endpackage

>>> rtl/core/blpc_button.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_button
// Per-button tracker: keeps the pressed flag, long-fired flag and press
// time, and classifies one poll into press, long press, release or nothing.
// ----------------------------------------------------------------------------
module blpc_button #(
  parameter int unsigned BTN_IDX    = 0,
  parameter int unsigned TIME_WIDTH = blpc_pkg::TimeWDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           update_i,
  input  logic                           pressed_i,
  input  logic [blpc_pkg::StampW-1:0]    now_i,
  input  logic [blpc_pkg::HoldW-1:0]     hold_i,
  output logic                           hit_o,
  output blpc_pkg::event_t               evt_o
);

  // common width for the elapsed time compare
  localparam int unsigned CmpW =
    (TIME_WIDTH > blpc_pkg::HoldW) ? TIME_WIDTH : blpc_pkg::HoldW;
  localparam int unsigned ExtW =
    (TIME_WIDTH > blpc_pkg::StampW) ? TIME_WIDTH : blpc_pkg::StampW;

  logic                  was_q, was_d;
  logic                  ld_q, ld_d;
  logic [TIME_WIDTH-1:0] stamp_q, stamp_d;

  logic [ExtW-1:0]       now_ext;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  long_ok;

  // timestamp taken modulo the time range
  assign now_ext = ExtW'(now_i);
  assign now_t   = now_ext[TIME_WIDTH-1:0];
  assign elapsed = now_t - stamp_q;
  assign long_ok = CmpW'(elapsed) >= CmpW'(hold_i);

  // classify and compute next state
  always_comb begin
    was_d   = pressed_i;
    ld_d    = ld_q;
    stamp_d = stamp_q;
    hit_o   = 1'b0;
    evt_o.button       = 2'(BTN_IDX);
    evt_o.action       = blpc_pkg::ACT_PRESS;
    evt_o.interaction  = blpc_pkg::INTER_NONE;
    evt_o.volume_valid = 1'b0;
    evt_o.volume_value = blpc_pkg::VolNone;
    evt_o.last         = 1'b0;
    priority if (pressed_i && !was_q) begin
      // new press
      hit_o   = 1'b1;
      stamp_d = now_t;
      ld_d    = 1'b0;
      evt_o.action = blpc_pkg::ACT_PRESS;
      if (BTN_IDX == 1) begin
        evt_o.interaction = blpc_pkg::INTER_DOWN;
      end
    end else if (pressed_i && !ld_q && long_ok) begin
      // hold time reached
      hit_o = 1'b1;
      ld_d  = 1'b1;
      evt_o.action = blpc_pkg::ACT_LONG;
      if (BTN_IDX == 2) begin
        evt_o.volume_valid = 1'b1;
        evt_o.volume_value = blpc_pkg::VolMax;
      end else if (BTN_IDX == 3) begin
        evt_o.volume_valid = 1'b1;
        evt_o.volume_value = blpc_pkg::VolMin;
      end
    end else if (!pressed_i && was_q) begin
      // release
      hit_o   = 1'b1;
      stamp_d = '0;
      evt_o.action = blpc_pkg::ACT_RELEASE;
      if (BTN_IDX == 0) begin
        if (!ld_q) evt_o.interaction = blpc_pkg::INTER_TOGGLE;
      end else if (BTN_IDX == 1) begin
        evt_o.interaction = blpc_pkg::INTER_UP;
      end else if (BTN_IDX == 2) begin
        if (!ld_q) begin
          evt_o.volume_valid = 1'b1;
          evt_o.volume_value = blpc_pkg::VolUp;
        end
      end else begin
        if (!ld_q) begin
          evt_o.volume_valid = 1'b1;
          evt_o.volume_value = blpc_pkg::VolDown;
        end
      end
    end
  end

  // button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_q   <= 1'b0;
      ld_q    <= 1'b0;
      stamp_q <= '0;
    end else if (update_i) begin
      was_q   <= was_d;
      ld_q    <= ld_d;
      stamp_q <= stamp_d;
    end
  end

endmodule

>>> rtl/core/blpc_evbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_evbuf
// Event buffer: holds the events of one poll, one slot per button, and
// drains them in button order, one per output transfer.
// ----------------------------------------------------------------------------
module blpc_evbuf (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [blpc_pkg::NumBtn-1:0]         hits_i,
  input  blpc_pkg::event_t                    evts_i [blpc_pkg::NumBtn],
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output blpc_pkg::event_t                    out_data_o,
  output logic                                can_load_o,
  output logic [blpc_pkg::NumBtn-1:0]         pend_o
);

  logic [blpc_pkg::NumBtn-1:0] pend_q, pend_d;
  blpc_pkg::event_t            ev_q [blpc_pkg::NumBtn];
  logic [blpc_pkg::NumBtn-1:0] head_oh;
  logic [1:0]                  head_idx;
  logic                        single;
  logic                        pop;

  // lowest pending slot goes out first
  always_comb begin
    head_oh  = '0;
    head_idx = '0;
    for (int i = blpc_pkg::NumBtn - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        head_oh  = '0;
        head_oh[i] = 1'b1;
        head_idx = 2'(i);
      end
    end
  end

  assign single      = (pend_q & ~head_oh) == '0;
  assign out_valid_o = pend_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = !out_valid_o || (single && out_ready_i);
  assign pend_o      = pend_q;

  // output payload with last flag
  always_comb begin
    out_data_o      = ev_q[head_idx];
    out_data_o.last = single;
  end

  // pending mask update
  always_comb begin
    pend_d = pend_q;
    if (pop) pend_d = pend_q & ~head_oh;
    if (load_i) pend_d = hits_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // event slots
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < blpc_pkg::NumBtn; i++) begin
        ev_q[i] <= evts_i[i];
      end
    end
  end

endmodule

>>> rtl/core/button_press_long_press_classifier_unit.sv
`timescale 1ns / 1ps
// flow: a poll goes into the poll register, then its events into the buffer
// throughput: one poll per cycle while each poll yields at most one event
// and the output is ready; a poll with several events holds the single
// output port until all have transferred; polls without events give no output
// reset: buttons released, flags and press times cleared, hold time 2000000
// ----------------------------------------------------------------------------
// button_press_long_press_classifier_unit
// Four-button classifier: poll register, per-button trackers and an event
// buffer that sends press, long press and release events in button order.
// ----------------------------------------------------------------------------
module button_press_long_press_classifier_unit #(
  parameter int unsigned TIME_WIDTH = blpc_pkg::TimeWDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  blpc_pkg::poll_t                in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output blpc_pkg::event_t               out_data_o,
  input  logic                           cfg_we_i,
  input  logic [blpc_pkg::HoldW-1:0]     cfg_wdata_i
);

  logic [blpc_pkg::HoldW-1:0]  hold_q;
  logic                        st_valid_q;
  blpc_pkg::poll_t             st_q;
  logic                        can_load;
  logic                        fire;
  logic [blpc_pkg::NumBtn-1:0] hits;
  blpc_pkg::event_t            evts [blpc_pkg::NumBtn];
  logic [blpc_pkg::NumBtn-1:0] pend;

  // hold time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= blpc_pkg::HoldReset;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  // poll register
  assign fire       = st_valid_q && can_load;
  assign in_ready_o = !st_valid_q || can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      st_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      st_q <= in_data_i;
    end
  end

  // per-button classification
  for (genvar b = 0; b < blpc_pkg::NumBtn; b++) begin : g_btn
    blpc_button #(
      .BTN_IDX   (b),
      .TIME_WIDTH(TIME_WIDTH)
    ) u_button (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .update_i (fire),
      .pressed_i(!st_q.pin_levels[b]),
      .now_i    (st_q.now_time),
      .hold_i   (hold_q),
      .hit_o    (hits[b]),
      .evt_o    (evts[b])
    );
  end

  // event buffer and output
  blpc_evbuf u_evbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .hits_i     (hits),
    .evts_i     (evts),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .can_load_o (can_load),
    .pend_o     (pend)
  );

`ifndef SYNTH
  // events of one poll leave in rising button order
  a_btn_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      out_valid_o && (out_data_o.button > $past(out_data_o.button)))
    else $error("event order broken");

  // last marks the only pending event
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> $onehot(pend))
    else $error("last flag with more events pending");

  // a quiet poll leaves nothing to send
  a_quiet_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (hits == '0) |=> !out_valid_o)
    else $error("output from a quiet poll");
`endif

endmodule

>>> sim/blpc_score_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_score_pkg
// Scoreboard for the button long press classifier: keeps its own copy of the
// per-button press tracking, turns every transferred poll into the events it
// should cause, and checks each event transfer against the oldest one due.
// ----------------------------------------------------------------------------
package blpc_score_pkg;

  // button roles
  localparam int unsigned BtnChat    = 0;
  localparam int unsigned BtnTalk    = 1;
  localparam int unsigned BtnLouder  = 2;
  localparam int unsigned BtnQuieter = 3;

  class press_event_board;

    logic [blpc_pkg::HoldW-1:0]  hold_us;
    bit                          held_now[blpc_pkg::NumBtn];
    bit                          long_seen[blpc_pkg::NumBtn];
    logic [blpc_pkg::StampW-1:0] press_time[blpc_pkg::NumBtn];
    blpc_pkg::event_t            due_events[$];
    int unsigned                 errors;

    function new();
      hold_us = blpc_pkg::HoldReset;
      for (int i = 0; i < blpc_pkg::NumBtn; i++) begin
        held_now[i]   = 1'b0;
        long_seen[i]  = 1'b0;
        press_time[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_hold(logic [blpc_pkg::HoldW-1:0] value);
      hold_us = value;
    endfunction

    function int unsigned pending();
      return due_events.size();
    endfunction

    // classify one poll, queue the events it causes in button order
    function void note_poll(blpc_pkg::poll_t p);
      blpc_pkg::event_t            ev;
      blpc_pkg::event_t            batch[$];
      logic                        pressed;
      logic [blpc_pkg::StampW-1:0] held_for;
      for (int i = 0; i < blpc_pkg::NumBtn; i++) begin
        pressed  = ~p.pin_levels[i];
        held_for = p.now_time - press_time[i];
        ev              = '0;
        ev.button       = 2'(i);
        ev.interaction  = blpc_pkg::INTER_NONE;
        ev.volume_valid = 1'b0;
        ev.volume_value = blpc_pkg::VolNone;
        ev.last         = 1'b0;
        if (pressed && !held_now[i]) begin
          // new press
          press_time[i] = p.now_time;
          long_seen[i]  = 1'b0;
          ev.action     = blpc_pkg::ACT_PRESS;
          if (i == BtnTalk) ev.interaction = blpc_pkg::INTER_DOWN;
          batch.push_back(ev);
        end else if (pressed && !long_seen[i] && held_for >= hold_us) begin
          // held long enough, fires once per press
          long_seen[i] = 1'b1;
          ev.action    = blpc_pkg::ACT_LONG;
          if (i == BtnLouder) begin
            ev.volume_valid = 1'b1;
            ev.volume_value = blpc_pkg::VolMax;
          end else if (i == BtnQuieter) begin
            ev.volume_valid = 1'b1;
            ev.volume_value = blpc_pkg::VolMin;
          end
          batch.push_back(ev);
        end else if (!pressed && held_now[i]) begin
          // release, short presses carry the command, talk always sends up
          ev.action = blpc_pkg::ACT_RELEASE;
          if (i == BtnChat && !long_seen[i]) begin
            ev.interaction = blpc_pkg::INTER_TOGGLE;
          end else if (i == BtnTalk) begin
            ev.interaction = blpc_pkg::INTER_UP;
          end else if (i == BtnLouder && !long_seen[i]) begin
            ev.volume_valid = 1'b1;
            ev.volume_value = blpc_pkg::VolUp;
          end else if (i == BtnQuieter && !long_seen[i]) begin
            ev.volume_valid = 1'b1;
            ev.volume_value = blpc_pkg::VolDown;
          end
          press_time[i] = '0;
          batch.push_back(ev);
        end
        held_now[i] = pressed;
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) due_events.push_back(batch[k]);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    // compare one event transfer with the oldest event due
    task check_event(blpc_pkg::event_t got);
      blpc_pkg::event_t want;
      if (due_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event button %0d action %0d",
                                  got.button, got.action));
        return;
      end
      want = due_events.pop_front();
      if (got.button !== want.button)
        report_mismatch($sformatf("button got %0d want %0d", got.button, want.button));
      if (got.action !== want.action)
        report_mismatch($sformatf("button %0d action got %0d want %0d",
                                  want.button, got.action, want.action));
      if (got.interaction !== want.interaction)
        report_mismatch($sformatf("button %0d interaction got %0d want %0d",
                                  want.button, got.interaction, want.interaction));
      if (got.volume_valid !== want.volume_valid)
        report_mismatch($sformatf("button %0d volume_valid got %0b want %0b",
                                  want.button, got.volume_valid, want.volume_valid));
      if (got.volume_value !== want.volume_value)
        report_mismatch($sformatf("button %0d volume_value got %0d want %0d",
                                  want.button, got.volume_value, want.volume_value));
      if (got.last !== want.last)
        report_mismatch($sformatf("button %0d last got %0b want %0b",
                                  want.button, got.last, want.last));
    endtask

  endclass

endpackage

>>> sim/button_press_long_press_classifier_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_long_press_classifier_unit_test
// Drives polls of button levels and timestamps into the classifier with
// random gaps and output stalls, walks through several hold times including
// zero and the largest one, and checks every event against the scoreboard.
// ----------------------------------------------------------------------------
module button_press_long_press_classifier_unit_test;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  blpc_pkg::poll_t                  in_data_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  blpc_pkg::event_t                 out_data_o;
  logic                             cfg_we_i;
  logic [blpc_pkg::HoldW-1:0]       cfg_wdata_i;

  blpc_score_pkg::press_event_board board = new();
  bit                               idle_on = 1'b1;
  int unsigned                      rx_hold = 0;
  logic [blpc_pkg::StampW-1:0]      now_us;
  logic [3:0]                       levels;

  button_press_long_press_classifier_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 125 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        out_ready_i <= 1'b1;
        rx_hold = pick_gap();
      end
    end
  end

  // event transfers go to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_event(out_data_o);
  end

  // one poll transfer, valid stays up until accepted
  task automatic send_poll(logic [3:0] lv, logic [blpc_pkg::StampW-1:0] stamp);
    blpc_pkg::poll_t p;
    int unsigned     gap;
    p.pin_levels = lv;
    p.now_time   = stamp;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_poll(p);
  endtask

  // hold off polls until every due event is out, then let the pipe empty
  task automatic drain_events();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_hold(logic [blpc_pkg::HoldW-1:0] value);
    drain_events();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_hold(value);
  endtask

  // button levels drift, time steps scale with the hold time, some noise
  task automatic run_random(int unsigned count, logic [63:0] span);
    logic [63:0] step;
    logic [3:0]  flip;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 8) begin
        now_us = {16'($urandom), 32'($urandom)};
        levels = 4'($urandom);
      end else begin
        for (int b = 0; b < blpc_pkg::NumBtn; b++) flip[b] = ($urandom_range(0, 3) == 0);
        levels = levels ^ flip;
        if ($urandom_range(0, 3) == 0) step = 64'($urandom_range(0, 20));
        else step = (span * 64'($urandom_range(0, 200))) / 64'd100;
        now_us = now_us + step[blpc_pkg::StampW-1:0];
      end
      send_poll(levels, now_us);
      if (n % 45 == 44) drain_events();
    end
  endtask

  // generous limit on the whole run
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [blpc_pkg::HoldW-1:0] hold;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset hold time: quiet poll, boundary of the hold, long then release
    send_poll(4'hF, 48'd0);
    send_poll(4'h0, 48'd1000);
    send_poll(4'h0, 48'd2000999);
    send_poll(4'h0, 48'd2001000);
    send_poll(4'h0, 48'd5001000);
    send_poll(4'hF, 48'd6000000);
    // short presses across the top of the time range
    send_poll(4'h0, 48'hFFFF_FFFF_FFFF);
    send_poll(4'b0101, 48'd99);
    send_poll(4'hF, 48'd1999999);
    // long press measured across the time wrap
    send_poll(4'b1100, 48'hFFFF_FFF0_BDC0);
    send_poll(4'b1100, 48'd999999);
    send_poll(4'b1100, 48'd1000000);
    send_poll(4'hF, 48'd1000001);

    // zero hold: long fires on the poll after the press, never on the press
    write_hold('0);
    send_poll(4'b0011, 48'd500);
    send_poll(4'b0011, 48'd500);
    send_poll(4'hF, 48'd500);

    // largest hold: only the full-range difference reaches it
    write_hold('1);
    send_poll(4'b1011, 48'd5000);
    send_poll(4'b1011, 48'd4998);
    send_poll(4'b1011, 48'd4999);
    send_poll(4'hF, 48'd5000);

    // smallest nonzero hold
    write_hold(48'd1);
    send_poll(4'b1110, 48'd10);
    send_poll(4'b1110, 48'd10);
    send_poll(4'hF, 48'd10);

    // random phases over a few hold times
    levels = 4'hF;
    now_us = 48'd20;
    hold = blpc_pkg::HoldW'($urandom_range(1, 64));
    write_hold(hold);
    run_random(60, 64'(hold));

    now_us = 48'hFFFF_FFF0_0000;
    write_hold(blpc_pkg::HoldReset);
    run_random(60, 64'(blpc_pkg::HoldReset));

    hold = {16'h0, 32'($urandom)} | 48'd1;
    write_hold(hold);
    run_random(60, 64'(hold));

    drain_events();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
